FILE: rtl/nearest_seek_request_scheduler_defines.svh
// assertion macros for the nearest-seek request scheduler
// no dependencies; included by the top level only
`ifndef NEAREST_SEEK_REQUEST_SCHEDULER_DEFINES_SVH
`define NEAREST_SEEK_REQUEST_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nss check failed");

// next-cycle implication, checked out of reset
`define NSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nss check failed");

`endif

FILE: rtl/nss_pkg.sv
// shared constants, codes and types of the nearest-seek request scheduler
// no dependencies
package nss_pkg;
    localparam int QUEUE_DEPTH = 32;
    localparam int SECTOR_BITS = 48;
    localparam int TAG_BITS    = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_DISPATCH = 2'd1;
    localparam logic [1:0] CMD_REMOVE   = 2'd2;

    localparam logic [2:0] ST_DISPATCHED = 3'd0;
    localparam logic [2:0] ST_EMPTY      = 3'd1;
    localparam logic [2:0] ST_ADDED      = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_REMOVED    = 3'd4;
    localparam logic [2:0] ST_NOTFOUND   = 3'd5;

    typedef struct packed {
        logic [1:0]             command;
        logic [TAG_BITS-1:0]    tag;
        logic [SECTOR_BITS-1:0] sector;
    } cmd_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [TAG_BITS-1:0]    tag;
        logic [SECTOR_BITS-1:0] sector;
    } result_t;
endpackage

FILE: rtl/nearest_seek_request_scheduler.sv
// add and unused commands have their result registered when the command is accepted;
// dispatch and remove first scan the tag/sector ram one entry a cycle through a
// two-stage distance and compare pipeline, then register their result in S_DONE
// flow: one command at a time in the engine, a two-entry queue in front; the next
// command starts the cycle after a result leaves
// reset: aresetn synchronous, active low; clears valid bits, head and handshakes
// depends on nss_pkg, nss_cmd_fifo, nss_engine and the defines header
`include "nearest_seek_request_scheduler_defines.svh"
module nearest_seek_request_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // command[1:0], req_tag[9:2], req_sector[57:10], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // status[2:0], out_tag[10:3], out_sector[58:11], zeros
);
    localparam int TB = nss_pkg::TAG_BITS;
    localparam int SB = nss_pkg::SECTOR_BITS;

    nss_pkg::cmd_t    in_cmd, q_cmd;
    nss_pkg::result_t res;
    logic             q_valid, q_ready;

    // unpack input transaction
    assign in_cmd.command = s_tdata[1:0];
    assign in_cmd.tag     = s_tdata[2+TB-1:2];
    assign in_cmd.sector  = s_tdata[2+TB+SB-1:2+TB];

    nss_cmd_fifo u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    nss_engine u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // pack result transaction
    assign m_tdata = {{(64 - 3 - TB - SB){1'b0}}, res.sector, res.tag, res.status};

    // checks
    `NSS_ASSERT_NOW(a_status_range, m_tvalid, m_tdata[2:0] <= nss_pkg::ST_NOTFOUND)
    `NSS_ASSERT_NOW(a_zero_payload, m_tvalid && m_tdata[2:0] != nss_pkg::ST_DISPATCHED, m_tdata[58:3] == '0)
endmodule

FILE: rtl/nss_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module nss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

FILE: rtl/nss_cmd_fifo.sv
// front end: two-entry command queue between the input stream and the engine
// depends on nss_pkg
module nss_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  nss_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output nss_pkg::cmd_t out_cmd
);
    nss_pkg::cmd_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end
endmodule

FILE: rtl/nss_engine.sv
// back end: request table, sequential nearest-seek scan and result register
// depends on nss_pkg and nss_ram
module nss_engine (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  nss_pkg::cmd_t    cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output nss_pkg::result_t res
);
    localparam int D  = nss_pkg::QUEUE_DEPTH;
    localparam int IW = nss_pkg::IDX_W;
    localparam int CW = nss_pkg::CNT_W;
    localparam int SB = nss_pkg::SECTOR_BITS;
    localparam int TB = nss_pkg::TAG_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]    state_reg, state_next;
    nss_pkg::cmd_t cmd_reg, cmd_next;
    logic [D-1:0]  valid_reg, valid_next;
    logic [IW-1:0] age_reg [D];
    logic [IW-1:0] age_next [D];
    logic [SB-1:0] head_reg, head_next;
    logic [CW-1:0] issue_reg, issue_next;

    logic          s1_v_reg, s1_v_next;
    logic [IW-1:0] s1_idx_reg;
    logic          s2_v_reg, s2_v_next;
    logic [IW-1:0] s2_idx_reg;
    logic [SB-1:0] s2_dist_reg, s2_sec_reg;
    logic [TB-1:0] s2_tag_reg;
    logic [IW-1:0] s2_age_reg;

    logic          found_reg, found_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [SB-1:0] best_dist_reg, best_dist_next;
    logic [IW-1:0] best_age_reg, best_age_next;
    logic [TB-1:0] best_tag_reg, best_tag_next;
    logic [SB-1:0] best_sec_reg, best_sec_next;

    logic             res_valid_reg, res_valid_next;
    nss_pkg::result_t res_reg, res_next;

    logic          issuing, take;
    logic [IW-1:0] free_idx;
    logic          has_free;
    logic [CW-1:0] n_valid;
    logic          ram_we;
    logic [TB+SB-1:0] ram_rdata;
    logic [TB-1:0] rd_tag;
    logic [SB-1:0] rd_sec;
    logic [SB-1:0] s1_dist;
    logic          s1_hit;
    logic          better;

    assign cmd_ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign take      = cmd_valid && cmd_ready;
    assign issuing   = (state_reg == S_SCAN) && (issue_reg < CW'(D));
    assign ram_we    = take && (cmd.command == nss_pkg::CMD_ADD) && has_free;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign rd_tag    = ram_rdata[TB+SB-1:SB];
    assign rd_sec    = ram_rdata[SB-1:0];

    // tag and sector storage, read by the scan counter
    nss_ram #(.WIDTH(TB + SB), .DEPTH(D)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata ({cmd.tag, cmd.sector}),
        .raddr (issue_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    // lowest free slot and occupancy
    always_comb begin
        free_idx = '0;
        has_free = 1'b0;
        for (int i = D - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IW'(i);
                has_free = 1'b1;
            end
        end
        n_valid = CW'($countones(valid_reg));
    end

    // first scan stage: distance to head and candidate match
    always_comb begin
        s1_dist = (rd_sec >= head_reg) ? (rd_sec - head_reg) : (head_reg - rd_sec);
        s1_hit  = valid_reg[s1_idx_reg] &&
                  ((cmd_reg.command == nss_pkg::CMD_DISPATCH) || (rd_tag == cmd_reg.tag));
    end

    // second scan stage: compare against best so far
    always_comb begin
        if (!found_reg) begin
            better = 1'b1;
        end else if (cmd_reg.command == nss_pkg::CMD_DISPATCH) begin
            better = (s2_dist_reg < best_dist_reg) ||
                     ((s2_dist_reg == best_dist_reg) && (s2_age_reg < best_age_reg));
        end else begin
            better = (s2_age_reg < best_age_reg);
        end
    end

    // control and table update
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        valid_next     = valid_reg;
        age_next       = age_reg;
        head_next      = head_reg;
        issue_next     = issue_reg;
        s1_v_next      = issuing;
        s2_v_next      = s1_v_reg && s1_hit;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        best_age_next  = best_age_reg;
        best_tag_next  = best_tag_reg;
        best_sec_next  = best_sec_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;

        if (issuing) begin
            issue_next = issue_reg + CW'(1);
        end
        if (s2_v_reg && better) begin
            found_next     = 1'b1;
            best_idx_next  = s2_idx_reg;
            best_dist_next = s2_dist_reg;
            best_age_next  = s2_age_reg;
            best_tag_next  = s2_tag_reg;
            best_sec_next  = s2_sec_reg;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    cmd_next   = cmd;
                    issue_next = '0;
                    found_next = 1'b0;
                    res_next   = '{status: nss_pkg::ST_NOTFOUND, tag: '0, sector: '0};
                    priority if (cmd.command == nss_pkg::CMD_ADD) begin
                        res_valid_next = 1'b1;
                        if (has_free) begin
                            valid_next[free_idx] = 1'b1;
                            age_next[free_idx]   = n_valid[IW-1:0];
                            res_next.status      = nss_pkg::ST_ADDED;
                        end else begin
                            res_next.status = nss_pkg::ST_FULL;
                        end
                    end else if (cmd.command == nss_pkg::CMD_DISPATCH ||
                                 cmd.command == nss_pkg::CMD_REMOVE) begin
                        state_next = S_SCAN;
                    end else begin
                        res_valid_next = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (!issuing && !s1_v_reg && !s2_v_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                state_next     = S_IDLE;
                res_valid_next = 1'b1;
                res_next       = '{status: nss_pkg::ST_NOTFOUND, tag: '0, sector: '0};
                if (found_reg) begin
                    valid_next[best_idx_reg] = 1'b0;
                    for (int i = 0; i < D; i++) begin
                        if (valid_reg[i] && (age_reg[i] > best_age_reg)) begin
                            age_next[i] = age_reg[i] - IW'(1);
                        end
                    end
                end
                if (cmd_reg.command == nss_pkg::CMD_DISPATCH) begin
                    if (found_reg) begin
                        head_next = best_sec_reg;
                        res_next  = '{status: nss_pkg::ST_DISPATCHED, tag: best_tag_reg,
                                      sector: best_sec_reg};
                    end else begin
                        res_next.status = nss_pkg::ST_EMPTY;
                    end
                end else if (found_reg) begin
                    res_next.status = nss_pkg::ST_REMOVED;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            head_reg      <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            head_reg      <= head_next;
            s1_v_reg      <= s1_v_next;
            s2_v_reg      <= s2_v_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload and pipeline registers
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        age_reg       <= age_next;
        issue_reg     <= issue_next;
        s1_idx_reg    <= issue_reg[IW-1:0];
        s2_idx_reg    <= s1_idx_reg;
        s2_dist_reg   <= s1_dist;
        s2_sec_reg    <= rd_sec;
        s2_tag_reg    <= rd_tag;
        s2_age_reg    <= age_reg[s1_idx_reg];
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        best_age_reg  <= best_age_next;
        best_tag_reg  <= best_tag_next;
        best_sec_reg  <= best_sec_next;
        res_reg       <= res_next;
    end
endmodule
